>>> hw/rtl/consistent_hash_ring_router_macros.svh
// Assertion helpers for the ring router checker.
`ifndef CONSISTENT_HASH_RING_ROUTER_MACROS_SVH
`define CONSISTENT_HASH_RING_ROUTER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CHR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> hw/rtl/chr_pkg.sv
// ----------------------------------------------------------------------------
// chr_pkg
// Types, constants and helpers shared by the ring router modules.
// ----------------------------------------------------------------------------
`default_nettype none
package chr_pkg;
    localparam int MAX_ROUTEES = 16;
    localparam int MAX_VNODES  = 16;
    localparam int RING_DEPTH  = MAX_ROUTEES * MAX_VNODES;
    localparam int AW          = $clog2(RING_DEPTH);
    localparam int CW          = AW + 1;
    localparam int RW          = $clog2(MAX_ROUTEES + 1);
    localparam int VW          = 5;
    localparam logic [63:0] MIX_MUL    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] VNODE_STEP = 64'h94d049bb133111eb;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] routee_hash;
        logic [63:0] lookup_key;
    } t_in_word;

    typedef struct packed {
        logic [3:0] routee_index;
        logic [1:0] status;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX1,
        S_MIX2,
        S_MIX2B,
        S_MIX2C,
        S_MIX3,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_OWN_RD,
        S_OWN_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MIX1,
        OP_MIX2,
        OP_MIX2B,
        OP_MIX2C,
        OP_MIX3,
        OP_SCAN_RD,
        OP_SCAN_STEP,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_PUT,
        OP_SRCH_RD,
        OP_SRCH_STEP,
        OP_OWN_RD,
        OP_CLEAR,
        OP_RES
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status res_status;
    } t_ctl;

    typedef struct packed {
        logic is_add;
        logic is_lookup;
        logic is_clear;
        logic full;
        logic empty;
        logic vn_done;
        logic scan_done;
        logic shift_done;
        logic srch_done;
    } t_sts;
endpackage
`default_nettype wire

>>> hw/rtl/chr_datapath.sv
// ----------------------------------------------------------------------------
// chr_datapath
// Ring memory, hash mixer, insertion scan and shift, and binary search.
// ----------------------------------------------------------------------------
`default_nettype none
module chr_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire chr_pkg::t_in_word i_word,
    input  wire logic [4:0]        i_vnodes,
    input  wire chr_pkg::t_ctl     i_ctl,
    output chr_pkg::t_sts          o_sts,
    output chr_pkg::t_out_word     o_res
);
    localparam int AW = chr_pkg::AW;
    localparam int CW = chr_pkg::CW;
    localparam int RW = chr_pkg::RW;

    logic [63:0] mem_hash [chr_pkg::RING_DEPTH];
    logic [3:0]  mem_own  [chr_pkg::RING_DEPTH];
    logic [63:0] r_rd_hash;
    logic [3:0]  r_rd_own;

    logic [CW-1:0] r_ring_count;
    logic [RW-1:0] r_routee_count;
    logic [1:0]    r_cmd;
    logic [63:0]   r_base, r_key, r_h, r_mixed, r_vterm, r_prod;
    logic [4:0]    r_v, r_n;
    logic [CW-1:0] r_pos, r_k, r_lo, r_hi;
    logic [3:0]    r_owner;
    chr_pkg::t_out_word r_res;

    logic          we;
    logic [AW-1:0] wa, ra;
    logic [63:0]   wd_hash;
    logic [3:0]    wd_own;
    logic [CW-1:0] mid;
    logic [4:0]    n_lim;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_p;

    assign mid   = r_lo + ((r_hi - r_lo) >> 1);
    assign n_lim = (i_vnodes > 5'(chr_pkg::MAX_VNODES)) ? 5'(chr_pkg::MAX_VNODES) : i_vnodes;
    // One 32x32 multiplier builds the product mod 2^64 from three partial products.
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        we = 1'b0;
        wa = r_pos[AW-1:0];
        wd_hash = r_h;
        wd_own  = r_owner;
        ra = r_pos[AW-1:0];
        mul_a = r_h[31:0];
        mul_b = chr_pkg::MIX_MUL[31:0];
        case (i_ctl.op)
            chr_pkg::OP_MIX2B: mul_a = r_h[63:32];
            chr_pkg::OP_MIX2C: mul_b = chr_pkg::MIX_MUL[63:32];
            chr_pkg::OP_SHIFT_RD: ra = AW'(r_k - CW'(1));
            chr_pkg::OP_SHIFT_WR: begin
                we = 1'b1;
                wa = r_k[AW-1:0];
                wd_hash = r_rd_hash;
                wd_own  = r_rd_own;
            end
            chr_pkg::OP_PUT:     we = 1'b1;
            chr_pkg::OP_SRCH_RD: ra = mid[AW-1:0];
            // A key above every entry wraps to the first entry.
            chr_pkg::OP_OWN_RD:  ra = (r_lo >= r_ring_count) ? '0 : r_lo[AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_hash[wa] <= wd_hash;
            mem_own[wa]  <= wd_own;
        end
        r_rd_hash <= mem_hash[ra];
        r_rd_own  <= mem_own[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_count   <= '0;
            r_routee_count <= '0;
        end else begin
            case (i_ctl.op)
                chr_pkg::OP_CLEAR: begin
                    r_ring_count   <= '0;
                    r_routee_count <= '0;
                end
                chr_pkg::OP_PUT: r_ring_count <= r_ring_count + CW'(1);
                chr_pkg::OP_RES: begin
                    if (r_cmd == chr_pkg::CMD_ADD && i_ctl.res_status == chr_pkg::ST_OK)
                        r_routee_count <= r_routee_count + RW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            chr_pkg::OP_LOAD: begin
                r_cmd   <= i_word.command;
                r_base  <= i_word.routee_hash;
                r_key   <= i_word.lookup_key;
                r_v     <= '0;
                r_n     <= n_lim;
                r_vterm <= '0;
                r_owner <= r_routee_count[3:0];
                r_lo    <= '0;
                r_hi    <= r_ring_count;
            end
            chr_pkg::OP_MIX1:  r_h <= r_base ^ (r_base >> 30);
            chr_pkg::OP_MIX2:  r_prod <= mul_p;
            chr_pkg::OP_MIX2B: r_prod <= r_prod + {mul_p[31:0], 32'd0};
            chr_pkg::OP_MIX2C: r_h <= r_prod + {mul_p[31:0], 32'd0};
            chr_pkg::OP_MIX3: begin
                r_mixed <= r_h ^ (r_h >> 27);
                r_h     <= (r_h ^ (r_h >> 27)) + r_vterm;
                r_pos   <= '0;
            end
            chr_pkg::OP_SCAN_STEP: begin
                if (r_pos < r_ring_count && r_rd_hash <= r_h) r_pos <= r_pos + CW'(1);
                else r_k <= r_ring_count;
            end
            chr_pkg::OP_SHIFT_WR: r_k <= r_k - CW'(1);
            chr_pkg::OP_PUT: begin
                // The mixed base stays in r_mixed; the next vnode adds one more step.
                r_v     <= r_v + 5'd1;
                r_vterm <= r_vterm + chr_pkg::VNODE_STEP;
                r_h     <= r_mixed + r_vterm + chr_pkg::VNODE_STEP;
                r_pos   <= '0;
            end
            chr_pkg::OP_SRCH_STEP: begin
                if (r_rd_hash < r_key) r_lo <= mid + CW'(1);
                else r_hi <= mid;
            end
            chr_pkg::OP_OWN_RD: begin
                if (r_lo >= r_ring_count) r_lo <= '0;
            end
            chr_pkg::OP_RES: begin
                r_res.status <= i_ctl.res_status;
                if (i_ctl.res_status != chr_pkg::ST_OK) r_res.routee_index <= '0;
                else if (r_cmd == chr_pkg::CMD_ADD) r_res.routee_index <= r_owner;
                else if (r_cmd == chr_pkg::CMD_LOOKUP) r_res.routee_index <= r_rd_own;
                else r_res.routee_index <= '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.is_add     = r_cmd == chr_pkg::CMD_ADD;
        o_sts.is_lookup  = r_cmd == chr_pkg::CMD_LOOKUP;
        o_sts.is_clear   = r_cmd == chr_pkg::CMD_CLEAR;
        o_sts.full       = r_routee_count >= RW'(chr_pkg::MAX_ROUTEES);
        o_sts.empty      = r_ring_count == '0;
        o_sts.vn_done    = r_v >= r_n;
        o_sts.scan_done  = !(r_pos < r_ring_count && r_rd_hash <= r_h);
        o_sts.shift_done = r_k <= r_pos;
        o_sts.srch_done  = r_lo >= r_hi;
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

>>> hw/rtl/chr_ctrl.sv
// ----------------------------------------------------------------------------
// chr_ctrl
// Sequencer for clear, add (mix, scan, shift, put) and lookup (search).
// ----------------------------------------------------------------------------
`default_nettype none
module chr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire chr_pkg::t_sts i_sts,
    output chr_pkg::t_ctl      o_ctl
);
    chr_pkg::t_state r_state, n_state;
    logic r_res_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= chr_pkg::S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chr_pkg::S_IDLE: if (i_in_valid) n_state = chr_pkg::S_MIX1;
            chr_pkg::S_MIX1: begin
                if (i_sts.is_add && !i_sts.full) n_state = chr_pkg::S_MIX2;
                else if (i_sts.is_lookup && !i_sts.empty) n_state = chr_pkg::S_SRCH_RD;
                else n_state = chr_pkg::S_OUT;
            end
            chr_pkg::S_MIX2: n_state = chr_pkg::S_MIX2B;
            chr_pkg::S_MIX2B: n_state = chr_pkg::S_MIX2C;
            chr_pkg::S_MIX2C: n_state = chr_pkg::S_MIX3;
            chr_pkg::S_MIX3: n_state = i_sts.vn_done ? chr_pkg::S_OUT : chr_pkg::S_SCAN_RD;
            chr_pkg::S_SCAN_RD: n_state = chr_pkg::S_SCAN_CMP;
            chr_pkg::S_SCAN_CMP:
                n_state = i_sts.scan_done ? chr_pkg::S_SHIFT_RD : chr_pkg::S_SCAN_RD;
            chr_pkg::S_SHIFT_RD:
                n_state = i_sts.shift_done ? chr_pkg::S_PUT : chr_pkg::S_SHIFT_WR;
            chr_pkg::S_SHIFT_WR: n_state = chr_pkg::S_SHIFT_RD;
            chr_pkg::S_PUT: n_state = chr_pkg::S_OWN_WAIT;
            chr_pkg::S_OWN_WAIT:
                n_state = i_sts.vn_done ? chr_pkg::S_OUT : chr_pkg::S_SCAN_RD;
            chr_pkg::S_SRCH_RD:
                n_state = i_sts.srch_done ? chr_pkg::S_OWN_RD : chr_pkg::S_SRCH_CMP;
            chr_pkg::S_SRCH_CMP: n_state = chr_pkg::S_SRCH_RD;
            chr_pkg::S_OWN_RD: n_state = chr_pkg::S_OUT;
            chr_pkg::S_OUT: if (r_res_done && i_out_ready) n_state = chr_pkg::S_IDLE;
            default: n_state = chr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_res_done <= 1'b0;
        else if (r_state == chr_pkg::S_OUT) r_res_done <= 1'b1;
        else r_res_done <= 1'b0;
    end

    always_comb begin
        o_ctl.op = chr_pkg::OP_NONE;
        o_ctl.res_status = chr_pkg::ST_OK;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            chr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctl.op = chr_pkg::OP_LOAD;
            end
            chr_pkg::S_MIX1: begin
                if (i_sts.is_clear) o_ctl.op = chr_pkg::OP_CLEAR;
                else o_ctl.op = chr_pkg::OP_MIX1;
            end
            chr_pkg::S_MIX2: o_ctl.op = chr_pkg::OP_MIX2;
            chr_pkg::S_MIX2B: o_ctl.op = chr_pkg::OP_MIX2B;
            chr_pkg::S_MIX2C: o_ctl.op = chr_pkg::OP_MIX2C;
            chr_pkg::S_MIX3: o_ctl.op = chr_pkg::OP_MIX3;
            chr_pkg::S_SCAN_RD: o_ctl.op = chr_pkg::OP_SCAN_RD;
            chr_pkg::S_SCAN_CMP: o_ctl.op = chr_pkg::OP_SCAN_STEP;
            chr_pkg::S_SHIFT_RD: o_ctl.op = chr_pkg::OP_SHIFT_RD;
            chr_pkg::S_SHIFT_WR: o_ctl.op = chr_pkg::OP_SHIFT_WR;
            chr_pkg::S_PUT: o_ctl.op = chr_pkg::OP_PUT;
            chr_pkg::S_SRCH_RD: o_ctl.op = chr_pkg::OP_SRCH_RD;
            chr_pkg::S_SRCH_CMP: o_ctl.op = chr_pkg::OP_SRCH_STEP;
            chr_pkg::S_OWN_RD: o_ctl.op = chr_pkg::OP_OWN_RD;
            chr_pkg::S_OWN_WAIT: o_ctl.op = chr_pkg::OP_NONE;
            chr_pkg::S_OUT: begin
                // The routee count still holds its value from before this add here.
                if (!r_res_done) begin
                    o_ctl.op = chr_pkg::OP_RES;
                    if (i_sts.is_add && i_sts.full)
                        o_ctl.res_status = chr_pkg::ST_FULL;
                    else if (i_sts.is_lookup && i_sts.empty)
                        o_ctl.res_status = chr_pkg::ST_EMPTY;
                end
                o_out_valid = r_res_done;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> hw/rtl/consistent_hash_ring_router.sv
// Words are handled one at a time: a new word is accepted only in the idle state,
// after the result word of the previous one has been taken. A clear, an unused
// command, a rejected add or an empty-ring lookup goes straight to its result; a
// lookup first runs a binary search, and an add mixes, scans, shifts and puts each vnode.
// Reset (synchronous, active low) empties the ring and routee table and sets the
// vnode count register to 8; ring memory contents are not cleared.
// ----------------------------------------------------------------------------
// consistent_hash_ring_router
// Consistent-hash ring with virtual nodes: add, clear and lookup of routees.
// ----------------------------------------------------------------------------
`default_nettype none
module consistent_hash_ring_router (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire chr_pkg::t_in_word   i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output chr_pkg::t_out_word       o_out_word,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [4:0]          i_cfg_vnodes_per_routee
);
    // The register takes a write in any cycle; the vnode count is sampled when a
    // word is loaded, so writes belong between words.
    logic [4:0] r_vnodes;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vnodes <= 5'd8;
        else if (i_cfg_valid) r_vnodes <= i_cfg_vnodes_per_routee;
    end
    assign o_cfg_ready = 1'b1;

    chr_pkg::t_ctl ctl;
    chr_pkg::t_sts sts;

    chr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sts(sts), .o_ctl(ctl)
    );

    chr_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_word(i_in_word), .i_vnodes(r_vnodes),
        .i_ctl(ctl), .o_sts(sts), .o_res(o_out_word)
    );
endmodule
`default_nettype wire

>>> hw/rtl/chr_checker.sv
// ----------------------------------------------------------------------------
// chr_checker
// Port-level checks on the ring router handshakes and result status.
// ----------------------------------------------------------------------------
`default_nettype none
`include "consistent_hash_ring_router_macros.svh"
module chr_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic [1:0] o_status
);
    `CHR_ASSERT_IMP(a_no_in_while_out, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `CHR_ASSERT_NXT(a_out_after_take, i_clk, i_rst_n, o_out_valid && i_out_ready, !o_out_valid)
    `CHR_ASSERT_NXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `CHR_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_out_valid, o_status != chr_pkg::ST_RSVD)
endmodule
bind consistent_hash_ring_router chr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_status(o_out_word.status)
);
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives clear, add, lookup and unused words into the ring router with random
// gaps on both channels, predicts every result from a sorted ring kept here,
// and compares each returned word field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    chr_pkg::t_in_word   i_in_word;
    logic                o_out_valid;
    logic                i_out_ready;
    chr_pkg::t_out_word  o_out_word;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [4:0]          i_cfg_vnodes_per_routee;

    consistent_hash_ring_router uut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_in_word               (i_in_word),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_out_word              (o_out_word),
        .i_cfg_valid             (i_cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_vnodes_per_routee (i_cfg_vnodes_per_routee)
    );

    // Shadow copy of the ring: sorted hashes with their owners.
    logic [63:0] ring_hashes[$];
    logic [3:0]  ring_owners[$];
    int          routees_added;
    int          vnode_setting;

    chr_pkg::t_out_word pending_results[$];
    int          error_count;
    int          results_seen;
    int          words_sent;
    longint      cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The run is bounded: an add of 16 vnodes into a nearly full ring is the slowest
    // word, and the watchdog limit leaves room for every accepted add being that slow
    // along with the longest stalls; past the limit the run is reported as failed.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 20000000) begin
                $display("timeout with %0d results outstanding", pending_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic [63:0] point_hash(logic [63:0] base, int v);
        logic [63:0] h;
        h = base;
        h = h ^ (h >> 30);
        h = h * 64'hbf58476d1ce4e5b9;
        h = h ^ (h >> 27);
        h = h + 64'(v) * 64'h94d049bb133111eb;
        return h;
    endfunction

    // Equal hashes go after existing ones, so insertion order is preserved.
    function automatic void ring_place(logic [63:0] h, logic [3:0] owner);
        int pos;
        pos = 0;
        while (pos < ring_hashes.size() && ring_hashes[pos] <= h) pos++;
        ring_hashes.insert(pos, h);
        ring_owners.insert(pos, owner);
    endfunction

    function automatic chr_pkg::t_out_word predict_route(chr_pkg::t_in_word w);
        chr_pkg::t_out_word r;
        int n;
        int lo;
        int hi;
        int mid;
        r.routee_index = 4'd0;
        r.status = chr_pkg::ST_OK;
        case (chr_pkg::t_cmd'(w.command))
            chr_pkg::CMD_CLEAR: begin
                ring_hashes.delete();
                ring_owners.delete();
                routees_added = 0;
            end
            chr_pkg::CMD_ADD: begin
                if (routees_added >= chr_pkg::MAX_ROUTEES) begin
                    r.status = chr_pkg::ST_FULL;
                end else begin
                    n = (vnode_setting > chr_pkg::MAX_VNODES) ? chr_pkg::MAX_VNODES
                                                              : vnode_setting;
                    for (int v = 0; v < n; v++)
                        ring_place(point_hash(w.routee_hash, v), 4'(routees_added));
                    r.routee_index = 4'(routees_added);
                    routees_added++;
                end
            end
            chr_pkg::CMD_LOOKUP: begin
                if (ring_hashes.size() == 0) begin
                    r.status = chr_pkg::ST_EMPTY;
                end else begin
                    lo = 0;
                    hi = ring_hashes.size();
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (ring_hashes[mid] < w.lookup_key) lo = mid + 1;
                        else hi = mid;
                    end
                    if (lo >= ring_hashes.size()) lo = 0;
                    r.routee_index = ring_owners[lo];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Result side: random stalls, and each accepted word is compared with
    // the oldest prediction.
    initial begin
        int stall;
        chr_pkg::t_out_word want;
        i_out_ready = 1'b0;
        error_count = 0;
        results_seen = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            repeat (stall) @(negedge i_clk);
            i_out_ready = 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_word.routee_index !== want.routee_index) begin
                    $error("routee_index: expected %0d, actual %0d",
                           want.routee_index, o_out_word.routee_index);
                    error_count++;
                end
                if (o_out_word.status !== want.status) begin
                    $error("status: expected %0d, actual %0d",
                           want.status, o_out_word.status);
                    error_count++;
                end
            end
            results_seen++;
            @(negedge i_clk);
            i_out_ready = 1'b0;
        end
    end

    // Sends one word after a random gap; the prediction is queued when the
    // word is accepted.
    task automatic send_word(chr_pkg::t_cmd cmd, logic [63:0] base, logic [63:0] key,
                             bit no_gap = 0);
        int gap;
        chr_pkg::t_in_word w;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        repeat (gap) @(negedge i_clk);
        w.command = cmd;
        w.routee_hash = base;
        w.lookup_key = key;
        i_in_word = w;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(predict_route(w));
        words_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Writing the register only while nothing is in flight.
    task automatic write_vnodes(int value);
        wait_drained();
        i_cfg_vnodes_per_routee = 5'(value);
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        vnode_setting = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Directed: empty ring, extreme hashes and keys, duplicate routees,
    // zero vnodes, a vnode setting above the cap and the unused command.
    task automatic test_directed();
        send_word(chr_pkg::CMD_LOOKUP, '0, 64'd5);
        send_word(chr_pkg::CMD_NONE, '1, '1);
        send_word(chr_pkg::CMD_ADD, 64'd0, '0);
        send_word(chr_pkg::CMD_ADD, '1, '0);
        send_word(chr_pkg::CMD_ADD, 64'd0, '0);
        send_word(chr_pkg::CMD_LOOKUP, '0, 64'd0);
        send_word(chr_pkg::CMD_LOOKUP, '0, '1);
        send_word(chr_pkg::CMD_LOOKUP, '0, 64'h8000_0000_0000_0000);
        send_word(chr_pkg::CMD_CLEAR, '1, '1);
        send_word(chr_pkg::CMD_LOOKUP, '0, '0);
        write_vnodes(0);
        send_word(chr_pkg::CMD_ADD, rand64(), '0);
        send_word(chr_pkg::CMD_LOOKUP, '0, rand64());
        write_vnodes(31);
        for (int i = 0; i < 6; i++) send_word(chr_pkg::CMD_ADD, rand64(), '0);
        send_word(chr_pkg::CMD_LOOKUP, '0, rand64());
        send_word(chr_pkg::CMD_LOOKUP, '0, '1);
    endtask

    // Fills the table at the given vnode setting, with two adds past full, then looks up.
    task automatic test_full_table(int vn);
        write_vnodes(vn);
        send_word(chr_pkg::CMD_CLEAR, rand64(), rand64());
        for (int i = 0; i < chr_pkg::MAX_ROUTEES + 2; i++)
            send_word(chr_pkg::CMD_ADD, rand64(), '0);
        for (int i = 0; i < 8; i++) send_word(chr_pkg::CMD_LOOKUP, '0, rand64());
    endtask

    // Random mix: mostly lookups, some adds, with clears and unused words as noise.
    task automatic test_random(int count, int vn);
        int pick;
        write_vnodes(vn);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) send_word(chr_pkg::CMD_CLEAR, rand64(), rand64());
            else if (pick < 5) send_word(chr_pkg::CMD_NONE, rand64(), rand64());
            else if (pick < 20) send_word(chr_pkg::CMD_ADD, rand64(), rand64());
            else if (pick < 25 && ring_hashes.size() != 0)
                send_word(chr_pkg::CMD_LOOKUP, rand64(),
                          ring_hashes[$urandom_range(0, ring_hashes.size() - 1)]);
            else send_word(chr_pkg::CMD_LOOKUP, rand64(), rand64());
        end
    endtask

    // Back-to-back words after the sender has held off until drained.
    task automatic test_burst();
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_word($urandom_range(0, 1) ? chr_pkg::CMD_LOOKUP : chr_pkg::CMD_ADD,
                      rand64(), rand64(), 1);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_cfg_valid = 1'b0;
        i_cfg_vnodes_per_routee = 5'd8;
        routees_added = 0;
        vnode_setting = 8;
        words_sent = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_full_table(16);
        test_full_table(1);
        test_random(250, 8);
        test_burst();
        test_random(200, 3);
        test_random(200, 16);
        test_random(150, 0);
        test_random(50, 31);

        wait_drained();
        $display("Sent %0d words (clear, add, lookup, unused), checked %0d results,",
                 words_sent, results_seen);
        $display("vnode settings 0, 1, 3, 8, 16 and 31, including full routee tables.");
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
